[sv/ccu_pkg.sv]
// Shared types, codes, flag constants and helper functions of the condition code unit.
`timescale 1ns / 1ps
`default_nettype none

package ccu_pkg;

   // Flag positions inside the five-bit condition code register.
   localparam logic [4:0] FLAG_X = 5'h10;
   localparam logic [4:0] FLAG_N = 5'h08;
   localparam logic [4:0] FLAG_Z = 5'h04;
   localparam logic [4:0] FLAG_V = 5'h02;
   localparam logic [4:0] FLAG_C = 5'h01;

   // Update kinds carried by a request transaction.
   typedef enum logic [4:0] {
      OP_HOLD      = 5'd0,
      OP_SETZ      = 5'd1,
      OP_SETXC     = 5'd2,
      OP_SETC      = 5'd3,
      OP_SETV      = 5'd4,
      OP_SETN      = 5'd5,
      OP_Z_ONLY    = 5'd6,
      OP_CLEARVC   = 5'd7,
      OP_NZVC      = 5'd8,
      OP_VC        = 5'd9,
      OP_ADD       = 5'd10,
      OP_SUB       = 5'd11,
      OP_ADDX      = 5'd12,
      OP_SUBX      = 5'd13,
      OP_NEG       = 5'd14,
      OP_NEGX      = 5'd15,
      OP_CMP       = 5'd16,
      OP_SHIFTZERO = 5'd17,
      OP_SHIFT     = 5'd18,
      OP_ROTATE    = 5'd19,
      OP_ROTATEX   = 5'd20,
      OP_NZ00      = 5'd21,
      OP_ABS       = 5'd22
   } op_type;

   // Condition codes tested against the new flags.
   typedef enum logic [3:0] {
      COND_T  = 4'd0,
      COND_F  = 4'd1,
      COND_HI = 4'd2,
      COND_LS = 4'd3,
      COND_CC = 4'd4,
      COND_CS = 4'd5,
      COND_NE = 4'd6,
      COND_EQ = 4'd7,
      COND_VC = 4'd8,
      COND_VS = 4'd9,
      COND_PL = 4'd10,
      COND_MI = 4'd11,
      COND_GE = 4'd12,
      COND_LT = 4'd13,
      COND_GT = 4'd14,
      COND_LE = 4'd15
   } cond_type;

   // Operand sizes for the sized N/Z update.
   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0,
      SIZE_WORD = 2'd1,
      SIZE_LONG = 2'd2,
      SIZE_QUAD = 2'd3
   } size_type;

   // Flag tables indexed by {result_msb, dest_msb, src_msb}.
   localparam logic [4:0] ADD_XNVC [8] = '{5'h00, 5'h11, 5'h11, 5'h13,
                                           5'h0a, 5'h08, 5'h08, 5'h19};
   localparam logic [4:0] SUB_XNVC [8] = '{5'h00, 5'h11, 5'h02, 5'h00,
                                           5'h19, 5'h1b, 5'h08, 5'h19};
   localparam logic [4:0] SUB_NVC  [8] = '{5'h00, 5'h01, 5'h02, 5'h00,
                                           5'h09, 5'h0b, 5'h08, 5'h09};

   // Payload of a request transaction.
   typedef struct packed {
      logic [4:0]  op;
      logic        zero_in;
      logic        result_msb;
      logic        dest_msb;
      logic        src_msb;
      logic        neg_in;
      logic        ovf_in;
      logic        carry_in;
      logic [63:0] result_value;
      logic [1:0]  result_size;
      logic [3:0]  cond;
   } req_type;

   // Payload of a response transaction.
   typedef struct packed {
      logic [4:0] ccr_out;
      logic       cond_true;
   } rsp_type;

   // Negative wins over zero when both are reported.
   function automatic logic [4:0] nz_prio(input logic n, input logic z);
      logic [4:0] f;
      f = n ? FLAG_N : (z ? FLAG_Z : 5'h00);
      return f;
   endfunction

   // Evaluates a condition code against a set of flags.
   function automatic logic eval_cond(input logic [4:0] f, input logic [3:0] cc);
      logic c;
      logic v;
      logic z;
      logic n;
      logic r;
      c = f[0];
      v = f[1];
      z = f[2];
      n = f[3];
      case (cond_type'(cc))
         COND_T:  r = 1'b1;
         COND_F:  r = 1'b0;
         COND_HI: r = !c && !z;
         COND_LS: r = c || z;
         COND_CC: r = !c;
         COND_CS: r = c;
         COND_NE: r = !z;
         COND_EQ: r = z;
         COND_VC: r = !v;
         COND_VS: r = v;
         COND_PL: r = !n;
         COND_MI: r = n;
         COND_GE: r = (n == v);
         COND_LT: r = (n != v);
         COND_GT: r = !z && (n == v);
         COND_LE: r = z || (n != v);
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/ccu_if.sv]
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps
`default_nettype none

interface ccu_req_if;
   logic             valid;
   logic             ready;
   ccu_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ccu_rsp_if;
   logic             valid;
   logic             ready;
   ccu_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/cpu_condition_code_unit.sv]
// Top level of the condition code unit: input register, flag update, result register.
//
//   channel  direction  handshake          payload
//   req_if   in         valid / ready      op, flag inputs, result_value, size, cond
//   rsp_if   out        valid / ready      ccr_out, cond_true
//
// A request transaction is captured in the input register and its response is then
// loaded into the response register; one transaction per cycle is sustained while
// rsp_if.ready is high. The flag and response registers load together when the input
// stage moves forward. Reset clears the flags to zero and empties both stages.
// A stalled response holds the input stage, which in turn drops req_if.ready once full.
`timescale 1ns / 1ps
`default_nettype none

module cpu_condition_code_unit (
   input wire logic  clock,
   input wire logic  reset,
   ccu_req_if.sink   req_if,
   ccu_rsp_if.source rsp_if
);

   logic             in_valid_ff;
   logic             in_valid_in;
   ccu_pkg::req_type in_data_ff;
   ccu_pkg::req_type in_data_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   ccu_pkg::rsp_type rsp_data_ff;
   ccu_pkg::rsp_type rsp_data_in;
   logic [4:0]       ccr_ff;
   logic [4:0]       ccr_in;
   logic [4:0]       ccr_next;
   logic             cond_true;
   logic             advance;
   logic             req_take;

   // Flag update on the registered transaction.
   ccu_flag_logic u_flag_logic (
      .ccr_cur   (ccr_ff),
      .req       (in_data_ff),
      .ccr_next  (ccr_next),
      .cond_true (cond_true)
   );

   // Stage control: the input stage moves when the response register is free.
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;
   assign req_take      = req_if.valid && req_if.ready;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   // Next values of the stage registers.
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ccr_in       = ccr_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in           = 1'b0;
         rsp_valid_in          = 1'b1;
         rsp_data_in.ccr_out   = ccr_next;
         rsp_data_in.cond_true = cond_true;
         ccr_in                = ccr_next;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_if.payload;
      end
   end

   // Control and flag registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ccr_ff       <= 5'h00;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         ccr_ff       <= ccr_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The flags only change when a transaction moves into the response register.
   a_ccr_stable_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=> $stable(ccr_ff))
      else $error("flags changed while the response was stalled");

   // A pending response always shows the current flag register.
   a_rsp_matches_ccr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.ccr_out == ccr_ff))
      else $error("response flags differ from the flag register");

   // A hold transaction leaves the flags unchanged.
   a_hold_keeps_flags: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_data_ff.op == ccu_pkg::OP_HOLD)) |=> $stable(ccr_ff))
      else $error("hold transaction changed the flags");

   // Reset leaves empty stages and cleared flags.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (ccr_ff == 5'h00) && !rsp_valid_ff && !in_valid_ff)
      else $error("state not cleared by reset");

endmodule

`default_nettype wire

[sv/ccu_flag_logic.sv]
// Combinational flag update and condition evaluation for one transaction.
`timescale 1ns / 1ps
`default_nettype none

module ccu_flag_logic (
   input  wire logic [4:0]       ccr_cur,
   input  wire ccu_pkg::req_type req,
   output logic [4:0]            ccr_next,
   output logic                  cond_true
);

   logic [2:0] idx;
   logic       sized_sign;
   logic       sized_zero;
   logic [4:0] f;
   logic [4:0] keep_x;
   logic [4:0] z_flag;
   logic [4:0] z_sticky;

   assign idx      = {req.result_msb, req.dest_msb, req.src_msb};
   assign keep_x   = ccr_cur & ccu_pkg::FLAG_X;
   assign z_flag   = req.zero_in ? ccu_pkg::FLAG_Z : 5'h00;
   // Extended arithmetic can only clear Z, never set it.
   assign z_sticky = req.zero_in ? (ccr_cur & ccu_pkg::FLAG_Z) : 5'h00;

   // Sign and zero of the result at the selected size.
   always_comb begin
      case (ccu_pkg::size_type'(req.result_size))
         ccu_pkg::SIZE_BYTE: begin
            sized_sign = req.result_value[7];
            sized_zero = (req.result_value[7:0] == 8'h00);
         end
         ccu_pkg::SIZE_WORD: begin
            sized_sign = req.result_value[15];
            sized_zero = (req.result_value[15:0] == 16'h0000);
         end
         ccu_pkg::SIZE_LONG: begin
            sized_sign = req.result_value[31];
            sized_zero = (req.result_value[31:0] == 32'h0000_0000);
         end
         default: begin
            sized_sign = req.result_value[63];
            sized_zero = (req.result_value == 64'h0);
         end
      endcase
   end

   // Next flag value for each update kind; unknown kinds hold the flags.
   always_comb begin
      f = ccr_cur;
      case (ccu_pkg::op_type'(req.op))
         ccu_pkg::OP_SETZ, ccu_pkg::OP_Z_ONLY: begin
            f = (ccr_cur & ~ccu_pkg::FLAG_Z) | z_flag;
         end
         ccu_pkg::OP_SETXC: begin
            f = (ccr_cur & ~(ccu_pkg::FLAG_X | ccu_pkg::FLAG_C))
              | (req.carry_in ? (ccu_pkg::FLAG_X | ccu_pkg::FLAG_C) : 5'h00);
         end
         ccu_pkg::OP_SETC: begin
            f = (ccr_cur & ~ccu_pkg::FLAG_C) | (req.carry_in ? ccu_pkg::FLAG_C : 5'h00);
         end
         ccu_pkg::OP_SETV: begin
            f = (ccr_cur & ~ccu_pkg::FLAG_V) | (req.ovf_in ? ccu_pkg::FLAG_V : 5'h00);
         end
         ccu_pkg::OP_SETN: begin
            f = (ccr_cur & ~ccu_pkg::FLAG_N) | (req.neg_in ? ccu_pkg::FLAG_N : 5'h00);
         end
         ccu_pkg::OP_CLEARVC: begin
            f = ccr_cur & ~(ccu_pkg::FLAG_V | ccu_pkg::FLAG_C);
         end
         ccu_pkg::OP_NZVC: begin
            f = keep_x | ccu_pkg::nz_prio(req.neg_in, req.zero_in)
              | (req.ovf_in ? ccu_pkg::FLAG_V : 5'h00)
              | (req.carry_in ? ccu_pkg::FLAG_C : 5'h00);
         end
         ccu_pkg::OP_VC: begin
            f = (ccr_cur & ~(ccu_pkg::FLAG_V | ccu_pkg::FLAG_C))
              | (req.ovf_in ? ccu_pkg::FLAG_V : 5'h00)
              | (req.carry_in ? ccu_pkg::FLAG_C : 5'h00);
         end
         ccu_pkg::OP_ADD:  f = z_flag | ccu_pkg::ADD_XNVC[idx];
         ccu_pkg::OP_SUB:  f = z_flag | ccu_pkg::SUB_XNVC[idx];
         ccu_pkg::OP_ADDX: f = z_sticky | ccu_pkg::ADD_XNVC[idx];
         ccu_pkg::OP_SUBX: f = z_sticky | ccu_pkg::SUB_XNVC[idx];
         ccu_pkg::OP_NEG: begin
            if (req.zero_in) begin
               f = ccu_pkg::FLAG_Z;
            end else begin
               f = ccu_pkg::FLAG_X | ccu_pkg::FLAG_C
                 | (req.result_msb ? ccu_pkg::FLAG_N : 5'h00)
                 | ((req.result_msb && req.dest_msb) ? ccu_pkg::FLAG_V : 5'h00);
            end
         end
         ccu_pkg::OP_NEGX: begin
            f = z_sticky;
            if (req.dest_msb || req.result_msb) begin
               f = z_sticky | ccu_pkg::FLAG_X | ccu_pkg::FLAG_C
                 | (req.result_msb ? ccu_pkg::FLAG_N : 5'h00)
                 | ((req.result_msb && req.dest_msb) ? ccu_pkg::FLAG_V : 5'h00);
            end
         end
         ccu_pkg::OP_CMP: begin
            f = keep_x | z_flag | ccu_pkg::SUB_NVC[idx];
         end
         ccu_pkg::OP_SHIFTZERO: begin
            f = keep_x | ccu_pkg::nz_prio(req.result_msb, req.zero_in);
         end
         ccu_pkg::OP_SHIFT: begin
            f = ccu_pkg::nz_prio(req.result_msb, req.zero_in)
              | (req.ovf_in ? ccu_pkg::FLAG_V : 5'h00)
              | (req.carry_in ? (ccu_pkg::FLAG_X | ccu_pkg::FLAG_C) : 5'h00);
         end
         ccu_pkg::OP_ROTATE: begin
            f = keep_x | ccu_pkg::nz_prio(req.result_msb, req.zero_in)
              | (req.carry_in ? ccu_pkg::FLAG_C : 5'h00);
         end
         ccu_pkg::OP_ROTATEX: begin
            f = z_flag | (req.result_msb ? ccu_pkg::FLAG_N : 5'h00)
              | (req.carry_in ? (ccu_pkg::FLAG_X | ccu_pkg::FLAG_C) : 5'h00);
         end
         ccu_pkg::OP_NZ00: begin
            f = keep_x | ccu_pkg::nz_prio(sized_sign, sized_zero);
         end
         ccu_pkg::OP_ABS: begin
            f = keep_x | (req.neg_in ? ccu_pkg::FLAG_N : 5'h00) | z_flag
              | (req.ovf_in ? ccu_pkg::FLAG_V : 5'h00)
              | (req.carry_in ? ccu_pkg::FLAG_C : 5'h00);
         end
         default: f = ccr_cur;
      endcase
   end

   assign ccr_next  = f;
   assign cond_true = ccu_pkg::eval_cond(f, req.cond);

endmodule

`default_nettype wire
